// File: sv/skbt_pkg.sv
// skbt_pkg: constants shared by the scalar kalman bias tracker
// register indexes, reset values and fixed widths; no dependencies
package skbt_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int GAIN_BITS     = 16;
	localparam int DIV_STEPS     = 64;

	typedef logic [31:0] word_t;
	typedef logic [16:0] gain_t;

	// configuration register indexes
	localparam logic [2:0] REG_PROCESS_NOISE    = 3'd0;
	localparam logic [2:0] REG_MEAS_NOISE       = 3'd1;
	localparam logic [2:0] REG_INITIAL_ESTIMATE = 3'd2;
	localparam logic [2:0] REG_INITIAL_VARIANCE = 3'd3;
	localparam logic [2:0] REG_ADAPT_NOISE      = 3'd4;
	localparam logic [2:0] REG_ADAPT_PERIOD     = 3'd5;
	localparam logic [2:0] REG_NIS_LIMIT        = 3'd6;

	// item codes
	localparam logic FUNC_UPDATE  = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	// register reset values
	localparam word_t       RST_PROCESS_NOISE    = 32'd66;
	localparam word_t       RST_MEAS_NOISE       = 32'd65536;
	localparam word_t       RST_INITIAL_ESTIMATE = 32'd0;
	localparam word_t       RST_INITIAL_VARIANCE = 32'd65536;
	localparam logic        RST_ADAPT_NOISE      = 1'b0;
	localparam logic [15:0] RST_ADAPT_PERIOD     = 16'd100;
	localparam word_t       RST_NIS_LIMIT        = 32'd589824;

endpackage

// File: sv/scalar_kalman_bias_tracker.sv
// scalar_kalman_bias_tracker: one-dimensional random-walk kalman filter
// with adaptive measurement noise; uses skbt_pkg
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid, in_stall, func, measurement      | into block
//   out     | out_valid, out_stall, filtered .. counts   | out of block
//   cfg     | cfg_we, cfg_index, cfg_data                | into block
//
// a measurement beat runs the gain and nis divisions, and with adaptation the ema division
// as well: a restoring divider retiring one quotient bit per cycle
// (64 steps) is shared by the gain, the nis and the ema divisions.
// zero innovation variance skips the gain and nis divisions.
// a restart beat reloads the filter state and goes to ST_FIN. in_stall is high while a beat is in work.
// the result sits in an output register, so the next beat is taken while it
// waits; a finished beat holds in ST_FIN until that register is free.
// reset loads the register defaults and the filter state at once.
module scalar_kalman_bias_tracker
	import skbt_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] measurement,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] filtered,
	output logic [31:0] innovation,
	output logic [31:0] nis_value,
	output logic [16:0] gain,
	output logic        mismatch,
	output logic [31:0] mismatch_count,
	output logic [31:0] update_count,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PREP  = 4'd1;
	localparam logic [3:0] ST_SQ    = 4'd2;
	localparam logic [3:0] ST_DK    = 4'd3;
	localparam logic [3:0] ST_DN    = 4'd4;
	localparam logic [3:0] ST_MK    = 4'd5;
	localparam logic [3:0] ST_EST   = 4'd6;
	localparam logic [3:0] ST_VAR   = 4'd7;
	localparam logic [3:0] ST_DE    = 4'd8;
	localparam logic [3:0] ST_NOISE = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	localparam logic [63:0] SQ_HALF   = 64'd1 << (FRAC_BITS - 1);
	localparam logic [48:0] GAIN_HALF = 49'd1 << (GAIN_BITS - 1);
	localparam logic [16:0] GAIN_ONE  = 17'd1 << GAIN_BITS;

	// configuration registers
	word_t       q_noise_q, r_fixed_q, x0_q, p0_q, nis_lim_q;
	logic        adapt_q;
	logic [15:0] period_q;

	// filter state
	word_t est_q, var_q, noise_q, avg_q, mism_q, upd_q;

	// per-item work registers
	logic [3:0]  state_q;
	word_t       p_pred_q, nu_q, mag_q, nis_q;
	logic [32:0] s_q;
	logic [63:0] sq_q;
	gain_t       k_q;
	logic [48:0] prod_q, vprod_q;
	logic        flag_q;

	// shared divider
	logic [32:0] div_rem_q, div_den_q;
	logic [63:0] div_quo_q;
	logic [6:0]  div_cnt_q;
	logic [33:0] div_trial;
	logic        div_ge;
	logic [32:0] div_rem_n;

	// combinational helpers
	logic [32:0] p_sum, nu_diff, est_sum, noise_cmp;
	logic [32:0] step;
	logic [63:0] sq_round, sample_wide;
	word_t       sample, ema_diff;
	logic        ema_up;
	logic [15:0] period_eff;
	logic        out_load;

	assign in_stall = (state_q != ST_IDLE);

	// finished beat moves into the output register when it is free or drains now
	assign out_load = (state_q == ST_FIN) && (!out_valid || !out_stall);

	assign div_trial = {div_rem_q, div_quo_q[63]};
	assign div_ge    = (div_trial >= {1'b0, div_den_q});
	assign div_rem_n = div_ge ? 33'(div_trial - {1'b0, div_den_q}) : div_trial[32:0];

	assign p_sum   = {1'b0, var_q} + {1'b0, q_noise_q};
	assign nu_diff = {measurement[31], measurement} - {est_q[31], est_q};
	assign step    = 33'((prod_q + GAIN_HALF) >> GAIN_BITS);
	assign est_sum = nu_q[31] ? ({est_q[31], est_q} - step) : ({est_q[31], est_q} + step);

	assign sq_round    = sq_q + SQ_HALF;
	assign sample_wide = sq_round >> FRAC_BITS;
	assign sample      = (|sample_wide[63:32]) ? 32'hFFFF_FFFF : sample_wide[31:0];
	assign ema_up      = (sample >= avg_q);
	assign ema_diff    = ema_up ? (sample - avg_q) : (avg_q - sample);
	assign period_eff  = (period_q == 16'd0) ? 16'd1 : period_q;
	assign noise_cmp   = {1'b0, p_pred_q} + 33'd1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= RST_PROCESS_NOISE;
			r_fixed_q <= RST_MEAS_NOISE;
			x0_q      <= RST_INITIAL_ESTIMATE;
			p0_q      <= RST_INITIAL_VARIANCE;
			adapt_q   <= RST_ADAPT_NOISE;
			period_q  <= RST_ADAPT_PERIOD;
			nis_lim_q <= RST_NIS_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROCESS_NOISE:    q_noise_q <= cfg_data;
				REG_MEAS_NOISE:       r_fixed_q <= cfg_data;
				REG_INITIAL_ESTIMATE: x0_q      <= cfg_data;
				REG_INITIAL_VARIANCE: p0_q      <= cfg_data;
				REG_ADAPT_NOISE:      adapt_q   <= cfg_data[0];
				REG_ADAPT_PERIOD:     period_q  <= cfg_data[15:0];
				REG_NIS_LIMIT:        nis_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			est_q     <= RST_INITIAL_ESTIMATE;
			var_q     <= RST_INITIAL_VARIANCE;
			noise_q   <= RST_MEAS_NOISE;
			avg_q     <= '0;
			mism_q    <= '0;
			upd_q     <= '0;
			out_valid <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (func == FUNC_RESTART) begin
							est_q   <= x0_q;
							var_q   <= p0_q;
							noise_q <= r_fixed_q;
							avg_q   <= '0;
							mism_q  <= '0;
							upd_q   <= '0;
							nu_q    <= '0;
							nis_q   <= '0;
							k_q     <= '0;
							flag_q  <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							if (upd_q != 32'hFFFF_FFFF) begin
								upd_q <= upd_q + 32'd1;
							end
							// saturating prediction and innovation
							p_pred_q <= p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
							if (nu_diff[32] != nu_diff[31]) begin
								nu_q <= nu_diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
							end else begin
								nu_q <= nu_diff[31:0];
							end
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					s_q     <= {1'b0, p_pred_q} + {1'b0, (adapt_q ? noise_q : r_fixed_q)};
					mag_q   <= nu_q[31] ? (32'd0 - nu_q) : nu_q;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					sq_q <= 64'(mag_q) * 64'(mag_q);
					if (s_q == 33'd0) begin
						k_q     <= '0;
						nis_q   <= '0;
						state_q <= ST_MK;
					end else begin
						// gain division: (p_pred << 16) / s
						div_rem_q <= '0;
						div_den_q <= s_q;
						div_quo_q <= {16'd0, p_pred_q, 16'd0};
						div_cnt_q <= 7'(DIV_STEPS);
						state_q   <= ST_DK;
					end
				end
				ST_DK: begin
					if (div_cnt_q != 7'd0) begin
						div_rem_q <= div_rem_n;
						div_quo_q <= {div_quo_q[62:0], div_ge};
						div_cnt_q <= div_cnt_q - 7'd1;
					end else begin
						k_q       <= div_quo_q[16:0];
						// nis division: nu^2 / s
						div_rem_q <= '0;
						div_quo_q <= sq_q;
						div_cnt_q <= 7'(DIV_STEPS);
						state_q   <= ST_DN;
					end
				end
				ST_DN: begin
					if (div_cnt_q != 7'd0) begin
						div_rem_q <= div_rem_n;
						div_quo_q <= {div_quo_q[62:0], div_ge};
						div_cnt_q <= div_cnt_q - 7'd1;
					end else begin
						nis_q   <= (|div_quo_q[63:32]) ? 32'hFFFF_FFFF : div_quo_q[31:0];
						state_q <= ST_MK;
					end
				end
				ST_MK: begin
					prod_q  <= 49'(k_q) * 49'(mag_q);
					state_q <= ST_EST;
				end
				ST_EST: begin
					// rounded step magnitude, sign from the innovation
					if (est_sum[32] != est_sum[31]) begin
						est_q <= est_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
					end else begin
						est_q <= est_sum[31:0];
					end
					vprod_q <= 49'(GAIN_ONE - k_q) * 49'(p_pred_q);
					state_q <= ST_VAR;
				end
				ST_VAR: begin
					var_q  <= 32'((vprod_q + GAIN_HALF) >> GAIN_BITS);
					flag_q <= (nis_q > nis_lim_q);
					if ((nis_q > nis_lim_q) && (mism_q != 32'hFFFF_FFFF)) begin
						mism_q <= mism_q + 32'd1;
					end
					if (adapt_q) begin
						// ema step: |sample - avg| / period
						div_rem_q <= '0;
						div_den_q <= {17'd0, period_eff};
						div_quo_q <= {32'd0, ema_diff};
						div_cnt_q <= 7'(DIV_STEPS);
						sq_q      <= {63'd0, ema_up};
						state_q   <= ST_DE;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DE: begin
					if (div_cnt_q != 7'd0) begin
						div_rem_q <= div_rem_n;
						div_quo_q <= {div_quo_q[62:0], div_ge};
						div_cnt_q <= div_cnt_q - 7'd1;
					end else begin
						// sq_q[0] holds the ema direction here
						avg_q   <= sq_q[0] ? (avg_q + div_quo_q[31:0])
								: (avg_q - div_quo_q[31:0]);
						state_q <= ST_NOISE;
					end
				end
				ST_NOISE: begin
					noise_q <= ({1'b0, avg_q} > noise_cmp) ? (avg_q - p_pred_q) : 32'd1;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			filtered       <= est_q;
			innovation     <= nu_q;
			nis_value      <= nis_q;
			gain           <= k_q;
			mismatch       <= flag_q;
			mismatch_count <= mism_q;
			update_count   <= upd_q;
		end
	end

endmodule
